/* src/spc_pkg.sv */
// shape pair collision test: shared constants, pair kind and result codes
// no dependencies; used by the interfaces, the top level, the segment lane and the checker
`default_nettype none

package spc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int CMD_W           = 3;
  localparam int HIT_W           = 2;

  // pair kinds
  localparam logic [CMD_W-1:0] CMD_RECT_RECT     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RECT_CIRCLE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RECT_SEGMENT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CIRCLE_CIRCLE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEG_SEG       = 3'd4;

  // result classes
  localparam logic [HIT_W-1:0] HIT_NONE     = 2'd0;
  localparam logic [HIT_W-1:0] HIT_STRAIGHT = 2'd1;
  localparam logic [HIT_W-1:0] HIT_DIAGONAL = 2'd2;

  // pipeline stage load enables handed to the segment lanes
  typedef struct packed {
    logic s2;
    logic s3;
  } spc_adv_t;

endpackage

`default_nettype wire

/* src/spc_in_if.sv */
// query channel: valid/ready handshake carrying one shape pair and its pair kind
// depends on spc_pkg
`default_nettype none

interface spc_in_if #(
  parameter int COORD_WIDTH = spc_pkg::COORD_WIDTH_DEF
);
  logic                            valid;
  logic                            ready;
  logic [spc_pkg::CMD_W-1:0]       cmd;
  logic signed [COORD_WIDTH-1:0]   a_x1;
  logic signed [COORD_WIDTH-1:0]   a_y1;
  logic signed [COORD_WIDTH-1:0]   a_x2;
  logic signed [COORD_WIDTH-1:0]   a_y2;
  logic [COORD_WIDTH-2:0]          a_radius;
  logic signed [COORD_WIDTH-1:0]   b_x1;
  logic signed [COORD_WIDTH-1:0]   b_y1;
  logic signed [COORD_WIDTH-1:0]   b_x2;
  logic signed [COORD_WIDTH-1:0]   b_y2;
  logic [COORD_WIDTH-2:0]          b_radius;

  modport source (
    output valid, cmd, a_x1, a_y1, a_x2, a_y2, a_radius,
    output b_x1, b_y1, b_x2, b_y2, b_radius,
    input  ready
  );

  modport sink (
    input  valid, cmd, a_x1, a_y1, a_x2, a_y2, a_radius,
    input  b_x1, b_y1, b_x2, b_y2, b_radius,
    output ready
  );
endinterface

`default_nettype wire

/* src/spc_out_if.sv */
// result channel: valid/ready handshake carrying one collision class
// depends on spc_pkg
`default_nettype none

interface spc_out_if;
  logic                      valid;
  logic                      ready;
  logic [spc_pkg::HIT_W-1:0] hit_kind;

  modport source (
    output valid, hit_kind,
    input  ready
  );

  modport sink (
    input  valid, hit_kind,
    output ready
  );
endinterface

`default_nettype wire

/* src/spc_seg_lane.sv */
// one segment crossing lane: differences, six registered cross-product terms,
// then the exact inclusive parameter test; depends on spc_pkg
`default_nettype none

module spc_seg_lane #(
  parameter int COORD_WIDTH = spc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  spc_pkg::spc_adv_t             adv,
  input  logic signed [COORD_WIDTH-1:0] p_x1,
  input  logic signed [COORD_WIDTH-1:0] p_y1,
  input  logic signed [COORD_WIDTH-1:0] p_x2,
  input  logic signed [COORD_WIDTH-1:0] p_y2,
  input  logic signed [COORD_WIDTH-1:0] q_x1,
  input  logic signed [COORD_WIDTH-1:0] q_y1,
  input  logic signed [COORD_WIDTH-1:0] q_x2,
  input  logic signed [COORD_WIDTH-1:0] q_y2,
  output logic                          hit
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;

  logic signed [DW-1:0] dx_nxt, dy_nxt, ex_nxt, ey_nxt, rx_nxt, ry_nxt;
  logic signed [DW-1:0] dx_r, dy_r, ex_r, ey_r, rx_r, ry_r;
  logic signed [PW-1:0] dxey_nxt, dyex_nxt, rxdy_nxt, rydx_nxt, rxey_nxt, ryex_nxt;
  logic signed [PW-1:0] dxey_r, dyex_r, rxdy_r, rydx_r, rxey_r, ryex_r;
  logic signed [CW-1:0] den, sn, tn;
  logic                 pos_ok, neg_ok;

  assign dx_nxt = DW'(p_x2) - DW'(p_x1);
  assign dy_nxt = DW'(p_y2) - DW'(p_y1);
  assign ex_nxt = DW'(q_x2) - DW'(q_x1);
  assign ey_nxt = DW'(q_y2) - DW'(q_y1);
  assign rx_nxt = DW'(q_x1) - DW'(p_x1);
  assign ry_nxt = DW'(q_y1) - DW'(p_y1);

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      ex_r <= ex_nxt;
      ey_r <= ey_nxt;
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
    end
  end

  assign dxey_nxt = dx_r * ey_r;
  assign dyex_nxt = dy_r * ex_r;
  assign rxdy_nxt = rx_r * dy_r;
  assign rydx_nxt = ry_r * dx_r;
  assign rxey_nxt = rx_r * ey_r;
  assign ryex_nxt = ry_r * ex_r;

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      dxey_r <= dxey_nxt;
      dyex_r <= dyex_nxt;
      rxdy_r <= rxdy_nxt;
      rydx_r <= rydx_nxt;
      rxey_r <= rxey_nxt;
      ryex_r <= ryex_nxt;
    end
  end

  assign den = CW'(dxey_r) - CW'(dyex_r);
  assign sn  = CW'(rxdy_r) - CW'(rydx_r);
  assign tn  = CW'(rxey_r) - CW'(ryex_r);

  // sign of the denominator picks the direction of the bounds, zero means parallel
  assign pos_ok = (den > 0) && (sn >= 0) && (sn <= den) && (tn >= 0) && (tn <= den);
  assign neg_ok = (den < 0) && (sn <= 0) && (sn >= den) && (tn <= 0) && (tn >= den);
  assign hit    = pos_ok || neg_ok;

endmodule

`default_nettype wire

/* src/shape_pair_collision_test_unit.sv */
// shape pair collision test, top level: four-stage pipeline over one query stream
// depends on spc_pkg, spc_in_if, spc_out_if and spc_seg_lane
//
//   channel | direction | handshake   | payload
//   in_if   | in        | valid/ready | cmd, a_x1..a_y2, a_radius, b_x1..b_y2, b_radius
//   out_if  | out       | valid/ready | hit_kind
//
// one item per cycle sustained while out_if takes results; an accepted item passes the input,
// operand and product registers before out_if.valid rises from the result register
// stages: input register, operand register, product register, result register;
// the product stage holds every multiplier, one product per lane term
// rst_n (synchronous) empties all stages; payload registers are not reset
// a stall on out_if holds each full stage, and in_if.ready stays high while any bubble is left
`default_nettype none

module shape_pair_collision_test_unit #(
  parameter int COORD_WIDTH = spc_pkg::COORD_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  spc_in_if.sink    in_if,
  spc_out_if.source out_if
);

  localparam int W   = COORD_WIDTH;
  localparam int DW  = W + 1;
  localparam int PW  = 2 * DW;
  localparam int NSL = 4;

  // stage occupancy and load enables
  logic v1_r, v2_r, v3_r, vo_r;
  logic rdy1, rdy2, rdy3, rdyo;
  spc_pkg::spc_adv_t adv;

  assign rdyo   = !vo_r || out_if.ready;
  assign rdy3   = !v3_r || rdyo;
  assign rdy2   = !v2_r || rdy3;
  assign rdy1   = !v1_r || rdy2;
  assign adv.s2 = rdy2;
  assign adv.s3 = rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_if.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdyo) vo_r <= v3_r;
    end
  end

  assign in_if.ready = rdy1;

  // stage 1: input register
  logic [spc_pkg::CMD_W-1:0] cmd_s1_r;
  logic signed [W-1:0]       ax1_r, ay1_r, ax2_r, ay2_r, bx1_r, by1_r, bx2_r, by2_r;
  logic [W-2:0]              ar_r, br_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      cmd_s1_r <= in_if.cmd;
      ax1_r    <= in_if.a_x1;
      ay1_r    <= in_if.a_y1;
      ax2_r    <= in_if.a_x2;
      ay2_r    <= in_if.a_y2;
      ar_r     <= in_if.a_radius;
      bx1_r    <= in_if.b_x1;
      by1_r    <= in_if.b_y1;
      bx2_r    <= in_if.b_x2;
      by2_r    <= in_if.b_y2;
      br_r     <= in_if.b_radius;
    end
  end

  // stage 1 -> 2: compares, corner selection and square operands
  logic                 rr_hit_nxt, start_in_nxt, box_nxt, early_nxt;
  logic                 in_x, in_y;
  logic signed [DW-1:0] cx_e, cy_e, r_e;
  logic signed [W-1:0]  kx, ky, u_base, u_ref, v_base, v_ref;
  logic signed [DW-1:0] u_nxt, v_nxt;
  logic [W-1:0]         w_nxt;

  assign rr_hit_nxt   = (ax1_r <= bx2_r) && (bx1_r <= ax2_r) &&
                        (ay1_r <= by2_r) && (by1_r <= ay2_r);
  assign start_in_nxt = (ax1_r < bx1_r) && (bx1_r < ax2_r) &&
                        (ay1_r < by1_r) && (by1_r < ay2_r);

  assign cx_e = DW'(bx1_r);
  assign cy_e = DW'(by1_r);
  assign r_e  = signed'(DW'(br_r));

  // box widened by the radius
  assign box_nxt = (DW'(ax1_r) <= cx_e + r_e) && (DW'(ax2_r) >= cx_e - r_e) &&
                   (DW'(ay1_r) <= cy_e + r_e) && (DW'(ay2_r) >= cy_e - r_e);

  always_comb begin
    in_x = 1'b0;
    in_y = 1'b0;
    kx   = ax1_r;
    ky   = ay1_r;
    if (bx1_r <= ax1_r) begin
      kx = ax1_r;
    end else if (bx1_r >= ax2_r) begin
      kx = ax2_r;
    end else begin
      in_x = 1'b1;
    end
    if (by1_r <= ay1_r) begin
      ky = ay1_r;
    end else if (by1_r >= ay2_r) begin
      ky = ay2_r;
    end else begin
      in_y = 1'b1;
    end
  end

  assign early_nxt = in_x || in_y;

  always_comb begin
    if (cmd_s1_r == spc_pkg::CMD_CIRCLE_CIRCLE) begin
      u_base = bx1_r;
      u_ref  = ax1_r;
      v_base = by1_r;
      v_ref  = ay1_r;
      w_nxt  = W'(ar_r) + W'(br_r);
    end else begin
      u_base = kx;
      u_ref  = bx1_r;
      v_base = ky;
      v_ref  = by1_r;
      w_nxt  = W'(br_r);
    end
  end

  assign u_nxt = DW'(u_base) - DW'(u_ref);
  assign v_nxt = DW'(v_base) - DW'(v_ref);

  // stage 2: operand register
  logic [spc_pkg::CMD_W-1:0] cmd_s2_r;
  logic                      rr_hit_s2_r, start_in_s2_r, box_s2_r, early_s2_r;
  logic signed [DW-1:0]      u_s2_r, v_s2_r;
  logic [W-1:0]              w_s2_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      cmd_s2_r      <= cmd_s1_r;
      rr_hit_s2_r   <= rr_hit_nxt;
      start_in_s2_r <= start_in_nxt;
      box_s2_r      <= box_nxt;
      early_s2_r    <= early_nxt;
      u_s2_r        <= u_nxt;
      v_s2_r        <= v_nxt;
      w_s2_r        <= w_nxt;
    end
  end

  // stage 2 -> 3: squares
  logic signed [PW-1:0] uu_full, vv_full;
  logic [2*W-1:0]       ww_nxt;

  assign uu_full = u_s2_r * u_s2_r;
  assign vv_full = v_s2_r * v_s2_r;
  assign ww_nxt  = w_s2_r * w_s2_r;

  // stage 3: product register
  logic [spc_pkg::CMD_W-1:0] cmd_s3_r;
  logic                      rr_hit_s3_r, start_in_s3_r, box_s3_r, early_s3_r;
  logic [PW-2:0]             uu_s3_r, vv_s3_r;
  logic [2*W-1:0]            ww_s3_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      cmd_s3_r      <= cmd_s2_r;
      rr_hit_s3_r   <= rr_hit_s2_r;
      start_in_s3_r <= start_in_s2_r;
      box_s3_r      <= box_s2_r;
      early_s3_r    <= early_s2_r;
      uu_s3_r       <= uu_full[PW-2:0];
      vv_s3_r       <= vv_full[PW-2:0];
      ww_s3_r       <= ww_nxt;
    end
  end

  // segment lanes: lane 0 also serves segment-segment, the rest are rectangle edges
  logic signed [W-1:0] lp_x1, lp_y1, lp_x2, lp_y2, l0_qx1, l0_qy1, l0_qx2, l0_qy2;
  logic [NSL-1:0]      lane_hit;

  always_comb begin
    if (cmd_s1_r == spc_pkg::CMD_SEG_SEG) begin
      lp_x1  = ax1_r;
      lp_y1  = ay1_r;
      lp_x2  = ax2_r;
      lp_y2  = ay2_r;
      l0_qx1 = bx1_r;
      l0_qy1 = by1_r;
      l0_qx2 = bx2_r;
      l0_qy2 = by2_r;
    end else begin
      lp_x1  = bx1_r;
      lp_y1  = by1_r;
      lp_x2  = bx2_r;
      lp_y2  = by2_r;
      l0_qx1 = ax1_r;
      l0_qy1 = ay1_r;
      l0_qx2 = ax2_r;
      l0_qy2 = ay1_r;
    end
  end

  // top edge, or the first segment against the second
  spc_seg_lane #(.COORD_WIDTH(W)) u_lane_top (
    .clk(clk), .adv(adv),
    .p_x1(lp_x1), .p_y1(lp_y1), .p_x2(lp_x2), .p_y2(lp_y2),
    .q_x1(l0_qx1), .q_y1(l0_qy1), .q_x2(l0_qx2), .q_y2(l0_qy2),
    .hit(lane_hit[0])
  );

  // bottom edge
  spc_seg_lane #(.COORD_WIDTH(W)) u_lane_bottom (
    .clk(clk), .adv(adv),
    .p_x1(bx1_r), .p_y1(by1_r), .p_x2(bx2_r), .p_y2(by2_r),
    .q_x1(ax1_r), .q_y1(ay2_r), .q_x2(ax2_r), .q_y2(ay2_r),
    .hit(lane_hit[1])
  );

  // left edge
  spc_seg_lane #(.COORD_WIDTH(W)) u_lane_left (
    .clk(clk), .adv(adv),
    .p_x1(bx1_r), .p_y1(by1_r), .p_x2(bx2_r), .p_y2(by2_r),
    .q_x1(ax1_r), .q_y1(ay1_r), .q_x2(ax1_r), .q_y2(ay2_r),
    .hit(lane_hit[2])
  );

  // right edge
  spc_seg_lane #(.COORD_WIDTH(W)) u_lane_right (
    .clk(clk), .adv(adv),
    .p_x1(bx1_r), .p_y1(by1_r), .p_x2(bx2_r), .p_y2(by2_r),
    .q_x1(ax2_r), .q_y1(ay1_r), .q_x2(ax2_r), .q_y2(ay2_r),
    .hit(lane_hit[3])
  );

  // stage 3 -> out: distance compare and class selection
  logic [PW-1:0]             dist_sq;
  logic                      in_reach;
  logic [spc_pkg::HIT_W-1:0] hit_nxt, hit_r;

  assign dist_sq  = PW'(uu_s3_r) + PW'(vv_s3_r);
  assign in_reach = dist_sq <= PW'(ww_s3_r);

  always_comb begin
    case (cmd_s3_r)
      spc_pkg::CMD_RECT_RECT: begin
        hit_nxt = rr_hit_s3_r ? spc_pkg::HIT_STRAIGHT : spc_pkg::HIT_NONE;
      end
      spc_pkg::CMD_RECT_CIRCLE: begin
        if (!box_s3_r) begin
          hit_nxt = spc_pkg::HIT_NONE;
        end else if (early_s3_r || in_reach) begin
          hit_nxt = spc_pkg::HIT_DIAGONAL;
        end else begin
          hit_nxt = spc_pkg::HIT_NONE;
        end
      end
      spc_pkg::CMD_RECT_SEGMENT: begin
        hit_nxt = (|lane_hit || start_in_s3_r) ? spc_pkg::HIT_DIAGONAL : spc_pkg::HIT_NONE;
      end
      spc_pkg::CMD_CIRCLE_CIRCLE: begin
        hit_nxt = in_reach ? spc_pkg::HIT_DIAGONAL : spc_pkg::HIT_NONE;
      end
      spc_pkg::CMD_SEG_SEG: begin
        hit_nxt = lane_hit[0] ? spc_pkg::HIT_DIAGONAL : spc_pkg::HIT_NONE;
      end
      default: begin
        hit_nxt = spc_pkg::HIT_NONE;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rdyo) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_if.valid    = vo_r;
  assign out_if.hit_kind = hit_r;

endmodule

`default_nettype wire

/* src/spc_checker.sv */
// port-level checks for the shape pair collision test, bound to the top level
// depends on spc_pkg and shape_pair_collision_test_unit
`default_nettype none

module spc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [spc_pkg::CMD_W-1:0] in_cmd,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [spc_pkg::HIT_W-1:0] out_hit_kind
);

  logic acc, go;

  assign acc = in_valid && in_ready && rst_n;
  assign go  = out_ready && rst_n;

  // a shown result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // with the sink always ready, the result is up once its item has passed every stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc ##1 go ##1 go ##1 go |=> out_valid)
    else $error("item missing at expected latency");

  // undefined pair kinds answer no collision
  a_undef_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(acc, 4) && $past(go, 3) && $past(go, 2) && $past(go, 1) &&
    ($past(in_cmd, 4) > spc_pkg::CMD_SEG_SEG)
    |-> out_hit_kind == spc_pkg::HIT_NONE)
    else $error("undefined pair kind gave a collision");

endmodule

bind shape_pair_collision_test_unit spc_checker u_spc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .in_cmd      (in_if.cmd),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_hit_kind(out_if.hit_kind)
);

`default_nettype wire

/* tb/shape_pair_collision_test_unit_test.sv */
// testbench for shape_pair_collision_test_unit: directed table, then random shape pairs
// scored against an in-bench collision predictor; depends on spc_pkg, spc_in_if, spc_out_if
module shape_pair_collision_test_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PER_PHASE = 640;
  localparam int DRAIN_CYCLES     = 8;
  localparam int HOLD_OFF_CYCLES  = 120;

  // pair kind codes the block leaves undefined
  localparam logic [spc_pkg::CMD_W-1:0] CMD_SPARE_0 = 3'd5;
  localparam logic [spc_pkg::CMD_W-1:0] CMD_SPARE_1 = 3'd6;
  localparam logic [spc_pkg::CMD_W-1:0] CMD_SPARE_2 = 3'd7;

  typedef logic signed [spc_pkg::COORD_WIDTH_DEF-1:0] coord_t;
  typedef logic [spc_pkg::COORD_WIDTH_DEF-2:0]        radius_t;
  typedef logic [spc_pkg::HIT_W-1:0]                  hit_t;
  typedef logic [spc_pkg::CMD_W-1:0]                  cmd_t;

  typedef struct packed {
    cmd_t    cmd;
    coord_t  a_x1;
    coord_t  a_y1;
    coord_t  a_x2;
    coord_t  a_y2;
    radius_t a_radius;
    coord_t  b_x1;
    coord_t  b_y1;
    coord_t  b_x2;
    coord_t  b_y2;
    radius_t b_radius;
  } query_t;

  typedef struct packed {
    query_t q;
    logic   known;
    hit_t   hit;
  } dir_row_t;

  logic clk;
  logic rst_n;

  spc_in_if #(.COORD_WIDTH(spc_pkg::COORD_WIDTH_DEF)) in_if ();
  spc_out_if out_if ();

  shape_pair_collision_test_unit #(.COORD_WIDTH(spc_pkg::COORD_WIDTH_DEF)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  hit_t     hit_expected[$];
  dir_row_t directed_rows[$];
  int       send_idle_pct  = 12;
  int       recv_stall_pct = 55;
  int       hold_left      = 0;
  int       mismatches     = 0;
  int       queries_sent   = 0;
  int       results_seen   = 0;
  int       kind_tally[8];
  int       hit_tally[3];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("shape_pair_collision_test_unit test failed");
    $finish;
  end

  // ---------------- collision predictor ----------------

  function automatic bit segments_cross(input longint px1, py1, px2, py2,
                                        input longint qx1, qy1, qx2, qy2);
    longint dx, dy, ex, ey, rx, ry, den, sn, tn;
    dx  = px2 - px1;
    dy  = py2 - py1;
    ex  = qx2 - qx1;
    ey  = qy2 - qy1;
    rx  = qx1 - px1;
    ry  = qy1 - py1;
    den = dx * ey - dy * ex;
    sn  = rx * dy - ry * dx;
    tn  = rx * ey - ry * ex;
    // parallel, collinear and zero-length all fall out here
    if (den == 0) return 1'b0;
    if (den < 0) begin
      den = -den;
      sn  = -sn;
      tn  = -tn;
    end
    return sn >= 0 && sn <= den && tn >= 0 && tn <= den;
  endfunction

  function automatic hit_t circle_meets_rect(input longint x1, y1, x2, y2, cx, cy, r);
    longint kx, ky;
    if (!(x1 <= cx + r && x2 >= cx - r && y1 <= cy + r && y2 >= cy - r))
      return spc_pkg::HIT_NONE;
    if (cx <= x1) kx = x1;
    else if (cx >= x2) kx = x2;
    else return spc_pkg::HIT_DIAGONAL;
    if (cy <= y1) ky = y1;
    else if (cy >= y2) ky = y2;
    else return spc_pkg::HIT_DIAGONAL;
    return ((kx - cx) * (kx - cx) + (ky - cy) * (ky - cy) <= r * r)
           ? spc_pkg::HIT_DIAGONAL : spc_pkg::HIT_NONE;
  endfunction

  function automatic hit_t segment_meets_rect(input longint x1, y1, x2, y2,
                                              input longint sx1, sy1, sx2, sy2);
    if (segments_cross(sx1, sy1, sx2, sy2, x1, y1, x2, y1) ||
        segments_cross(sx1, sy1, sx2, sy2, x1, y2, x2, y2) ||
        segments_cross(sx1, sy1, sx2, sy2, x1, y1, x1, y2) ||
        segments_cross(sx1, sy1, sx2, sy2, x2, y1, x2, y2))
      return spc_pkg::HIT_DIAGONAL;
    // start point strictly inside, segment never reaching an edge
    if (x1 < sx1 && sx1 < x2 && y1 < sy1 && sy1 < y2) return spc_pkg::HIT_DIAGONAL;
    return spc_pkg::HIT_NONE;
  endfunction

  function automatic hit_t predict_hit(input query_t q);
    longint ax1, ay1, ax2, ay2, ar, bx1, by1, bx2, by2, br;
    ax1 = longint'(q.a_x1);
    ay1 = longint'(q.a_y1);
    ax2 = longint'(q.a_x2);
    ay2 = longint'(q.a_y2);
    ar  = longint'(q.a_radius);
    bx1 = longint'(q.b_x1);
    by1 = longint'(q.b_y1);
    bx2 = longint'(q.b_x2);
    by2 = longint'(q.b_y2);
    br  = longint'(q.b_radius);
    case (q.cmd)
      spc_pkg::CMD_RECT_RECT: begin
        return (ax1 <= bx2 && bx1 <= ax2 && ay1 <= by2 && by1 <= ay2)
               ? spc_pkg::HIT_STRAIGHT : spc_pkg::HIT_NONE;
      end
      spc_pkg::CMD_RECT_CIRCLE: begin
        return circle_meets_rect(ax1, ay1, ax2, ay2, bx1, by1, br);
      end
      spc_pkg::CMD_RECT_SEGMENT: begin
        return segment_meets_rect(ax1, ay1, ax2, ay2, bx1, by1, bx2, by2);
      end
      spc_pkg::CMD_CIRCLE_CIRCLE: begin
        return ((bx1 - ax1) * (bx1 - ax1) + (by1 - ay1) * (by1 - ay1) <= (ar + br) * (ar + br))
               ? spc_pkg::HIT_DIAGONAL : spc_pkg::HIT_NONE;
      end
      spc_pkg::CMD_SEG_SEG: begin
        return segments_cross(ax1, ay1, ax2, ay2, bx1, by1, bx2, by2)
               ? spc_pkg::HIT_DIAGONAL : spc_pkg::HIT_NONE;
      end
      default: begin
        return spc_pkg::HIT_NONE;
      end
    endcase
  endfunction

  // ---------------- stimulus ----------------

  task automatic add_row(input cmd_t cmd, input int ax1, ay1, ax2, ay2, ar,
                         input int bx1, by1, bx2, by2, br, input bit known, input hit_t hit);
    dir_row_t row;
    row.q.cmd      = cmd;
    row.q.a_x1     = coord_t'(ax1);
    row.q.a_y1     = coord_t'(ay1);
    row.q.a_x2     = coord_t'(ax2);
    row.q.a_y2     = coord_t'(ay2);
    row.q.a_radius = radius_t'(ar);
    row.q.b_x1     = coord_t'(bx1);
    row.q.b_y1     = coord_t'(by1);
    row.q.b_x2     = coord_t'(bx2);
    row.q.b_y2     = coord_t'(by2);
    row.q.b_radius = radius_t'(br);
    row.known      = known;
    row.hit        = hit;
    directed_rows.push_back(row);
  endtask

  // rows with known = 0 are scored by the predictor
  task automatic build_directed_rows();
    add_row(spc_pkg::CMD_RECT_RECT, 0, 0, 10, 10, 0, 5, 5, 20, 20, 0,
            1'b1, spc_pkg::HIT_STRAIGHT);
    add_row(spc_pkg::CMD_RECT_RECT, 0, 0, 10, 10, 0, 10, 0, 20, 10, 0,
            1'b1, spc_pkg::HIT_STRAIGHT);
    add_row(spc_pkg::CMD_RECT_RECT, 0, 0, 10, 10, 0, 11, 0, 20, 10, 0,
            1'b1, spc_pkg::HIT_NONE);
    add_row(spc_pkg::CMD_RECT_RECT, -32768, -32768, 32767, 32767, 32767,
            -32768, -32768, 32767, 32767, 32767, 1'b1, spc_pkg::HIT_STRAIGHT);
    add_row(spc_pkg::CMD_RECT_RECT, 10, 0, 0, 10, 0, 2, 2, 8, 8, 0,
            1'b1, spc_pkg::HIT_NONE);
    add_row(spc_pkg::CMD_RECT_RECT, 10, 10, 0, 0, 0, 0, 0, 10, 10, 0,
            1'b0, spc_pkg::HIT_NONE);
    add_row(spc_pkg::CMD_RECT_CIRCLE, 0, 0, 10, 10, 0, 5, 15, 0, 0, 5,
            1'b1, spc_pkg::HIT_DIAGONAL);
    add_row(spc_pkg::CMD_RECT_CIRCLE, 0, 0, 10, 10, 0, 13, 14, 0, 0, 5,
            1'b0, spc_pkg::HIT_NONE);
    add_row(spc_pkg::CMD_RECT_CIRCLE, 0, 0, 10, 10, 0, 100, 100, 0, 0, 5,
            1'b1, spc_pkg::HIT_NONE);
    add_row(spc_pkg::CMD_RECT_CIRCLE, -32768, -32768, 32767, 32767, 0,
            32767, 32767, 0, 0, 32767, 1'b0, spc_pkg::HIT_NONE);
    add_row(spc_pkg::CMD_RECT_CIRCLE, -32768, -32768, 0, 0, 0, -32768, -32768, 0, 0, 0,
            1'b0, spc_pkg::HIT_NONE);
    add_row(spc_pkg::CMD_RECT_SEGMENT, 0, 0, 10, 10, 0, -5, 5, 15, 5, 0,
            1'b0, spc_pkg::HIT_NONE);
    add_row(spc_pkg::CMD_RECT_SEGMENT, 0, 0, 10, 10, 0, 2, 2, 3, 3, 0,
            1'b0, spc_pkg::HIT_NONE);
    add_row(spc_pkg::CMD_RECT_SEGMENT, 0, 0, 10, 10, 0, 0, 5, 0, 5, 0,
            1'b1, spc_pkg::HIT_NONE);
    add_row(spc_pkg::CMD_RECT_SEGMENT, -32768, -32768, 32767, 32767, 0,
            -32768, 0, 32767, 0, 0, 1'b0, spc_pkg::HIT_NONE);
    add_row(spc_pkg::CMD_CIRCLE_CIRCLE, 0, 0, 0, 0, 3, 3, 4, 0, 0, 2,
            1'b0, spc_pkg::HIT_NONE);
    add_row(spc_pkg::CMD_CIRCLE_CIRCLE, -32768, -32768, 0, 0, 32767,
            32767, 32767, 0, 0, 32767, 1'b0, spc_pkg::HIT_NONE);
    add_row(spc_pkg::CMD_SEG_SEG, 0, 0, 10, 10, 0, 0, 10, 10, 0, 0,
            1'b0, spc_pkg::HIT_NONE);
    add_row(spc_pkg::CMD_SEG_SEG, 0, 0, 10, 0, 0, 10, 0, 10, 10, 0,
            1'b0, spc_pkg::HIT_NONE);
    add_row(spc_pkg::CMD_SEG_SEG, 0, 0, 10, 0, 0, 5, 0, 15, 0, 0,
            1'b1, spc_pkg::HIT_NONE);
    add_row(spc_pkg::CMD_SEG_SEG, 3, 3, 3, 3, 0, 0, 0, 10, 10, 0,
            1'b1, spc_pkg::HIT_NONE);
    add_row(spc_pkg::CMD_SEG_SEG, -32768, -32768, 32767, 32767, 0,
            -32768, 32767, 32767, -32768, 0, 1'b0, spc_pkg::HIT_NONE);
    add_row(CMD_SPARE_0, 0, 0, 10, 10, 5, 0, 0, 10, 10, 5, 1'b1, spc_pkg::HIT_NONE);
    add_row(CMD_SPARE_1, 0, 0, 10, 10, 5, 0, 0, 10, 10, 5, 1'b1, spc_pkg::HIT_NONE);
    add_row(CMD_SPARE_2, 0, 0, 10, 10, 5, 0, 0, 10, 10, 5, 1'b1, spc_pkg::HIT_NONE);
  endtask

  // mostly clustered around a random center so that shapes actually meet
  function automatic coord_t pick_coord(input int span_pick, input int center, input int spread);
    int v;
    if (span_pick < 10) return coord_t'($urandom());
    if (span_pick < 18) begin
      case ($urandom_range(0, 5))
        0: v = -32768;
        1: v = -32767;
        2: v = -1;
        3: v = 0;
        4: v = 32766;
        default: v = 32767;
      endcase
      return coord_t'(v);
    end
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return coord_t'(v);
  endfunction

  function automatic radius_t pick_radius(input int span_pick, input int spread);
    if (span_pick < 10) return radius_t'($urandom());
    if (span_pick < 18) begin
      case ($urandom_range(0, 2))
        0: return radius_t'(0);
        1: return radius_t'(1);
        default: return '1;
      endcase
    end
    return radius_t'($urandom_range(0, spread));
  endfunction

  function automatic query_t random_query();
    query_t q;
    int     span_pick, spread, center_x, center_y, lo, hi;
    coord_t t;
    span_pick = $urandom_range(0, 99);
    spread    = 8 << (4 * $urandom_range(0, 2));
    center_x  = int'($signed(16'($urandom())));
    center_y  = int'($signed(16'($urandom())));
    if ($urandom_range(0, 99) < 6)
      q.cmd = spc_pkg::CMD_W'($urandom_range(CMD_SPARE_0, CMD_SPARE_2));
    else
      q.cmd = spc_pkg::CMD_W'($urandom_range(spc_pkg::CMD_RECT_RECT, spc_pkg::CMD_SEG_SEG));
    q.a_x1     = pick_coord(span_pick, center_x, spread);
    q.a_y1     = pick_coord(span_pick, center_y, spread);
    q.a_x2     = pick_coord(span_pick, center_x, spread);
    q.a_y2     = pick_coord(span_pick, center_y, spread);
    q.a_radius = pick_radius(span_pick, spread);
    q.b_x1     = pick_coord(span_pick, center_x, spread);
    q.b_y1     = pick_coord(span_pick, center_y, spread);
    q.b_x2     = pick_coord(span_pick, center_x, spread);
    q.b_y2     = pick_coord(span_pick, center_y, spread);
    q.b_radius = pick_radius(span_pick, spread);
    // rectangles mostly well ordered, the rest left inverted
    if (q.cmd <= spc_pkg::CMD_RECT_SEGMENT && $urandom_range(0, 99) < 85) begin
      if (q.a_x1 > q.a_x2) begin
        t = q.a_x1; q.a_x1 = q.a_x2; q.a_x2 = t;
      end
      if (q.a_y1 > q.a_y2) begin
        t = q.a_y1; q.a_y1 = q.a_y2; q.a_y2 = t;
      end
    end
    if (q.cmd == spc_pkg::CMD_RECT_RECT && $urandom_range(0, 99) < 85) begin
      if (q.b_x1 > q.b_x2) begin
        t = q.b_x1; q.b_x1 = q.b_x2; q.b_x2 = t;
      end
      if (q.b_y1 > q.b_y2) begin
        t = q.b_y1; q.b_y1 = q.b_y2; q.b_y2 = t;
      end
    end
    // put the segment start strictly inside the rectangle now and then
    if (q.cmd == spc_pkg::CMD_RECT_SEGMENT && $urandom_range(0, 2) == 0) begin
      lo = q.a_x1;
      hi = q.a_x2;
      if (hi - lo > 1) q.b_x1 = coord_t'(lo + 1 + int'($urandom_range(0, hi - lo - 2)));
      lo = q.a_y1;
      hi = q.a_y2;
      if (hi - lo > 1) q.b_y1 = coord_t'(lo + 1 + int'($urandom_range(0, hi - lo - 2)));
    end
    return q;
  endfunction

  task automatic drive_payload(input query_t q);
    in_if.cmd      <= q.cmd;
    in_if.a_x1     <= q.a_x1;
    in_if.a_y1     <= q.a_y1;
    in_if.a_x2     <= q.a_x2;
    in_if.a_y2     <= q.a_y2;
    in_if.a_radius <= q.a_radius;
    in_if.b_x1     <= q.b_x1;
    in_if.b_y1     <= q.b_y1;
    in_if.b_x2     <= q.b_x2;
    in_if.b_y2     <= q.b_y2;
    in_if.b_radius <= q.b_radius;
  endtask

  // called at a rising edge; returns in the time step of the edge that took the item
  task automatic send_query(input query_t q, input bit known, input hit_t hit);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    drive_payload(q);
    do @(posedge clk); while (!in_if.ready);
    hit_expected.push_back(known ? hit : predict_hit(q));
    kind_tally[q.cmd]++;
    queries_sent++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (hit_expected.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // ---------------- result side ----------------

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin
    hit_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (out_if.hit_kind <= spc_pkg::HIT_DIAGONAL) hit_tally[out_if.hit_kind]++;
      if (hit_expected.size() == 0) begin
        flag_mismatch($sformatf("result %0d with no query pending", out_if.hit_kind));
      end else begin
        want = hit_expected.pop_front();
        if (out_if.hit_kind !== want)
          flag_mismatch($sformatf("hit_kind expected %0d, got %0d", want, out_if.hit_kind));
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    query_t blank;
    blank = '0;
    rst_n       <= 1'b0;
    in_if.valid <= 1'b0;
    drive_payload(blank);
    build_directed_rows();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_query(directed_rows[i].q, directed_rows[i].known, directed_rows[i].hit);
    repeat (RANDOM_PER_PHASE) send_query(random_query(), 1'b0, spc_pkg::HIT_NONE);
    drain_results();

    send_idle_pct  = 55;
    recv_stall_pct = 12;
    repeat (RANDOM_PER_PHASE) send_query(random_query(), 1'b0, spc_pkg::HIT_NONE);
    drain_results();

    // back-to-back items into a receiver that holds off, so the pipeline backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HOLD_OFF_CYCLES;
    repeat (RANDOM_PER_PHASE) send_query(random_query(), 1'b0, spc_pkg::HIT_NONE);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d queries; by pair kind rr %0d, rc %0d, rs %0d, cc %0d, ss %0d, undefined %0d",
             queries_sent, kind_tally[spc_pkg::CMD_RECT_RECT],
             kind_tally[spc_pkg::CMD_RECT_CIRCLE], kind_tally[spc_pkg::CMD_RECT_SEGMENT],
             kind_tally[spc_pkg::CMD_CIRCLE_CIRCLE], kind_tally[spc_pkg::CMD_SEG_SEG],
             kind_tally[CMD_SPARE_0] + kind_tally[CMD_SPARE_1] + kind_tally[CMD_SPARE_2]);
    $display("%0d results: none %0d, straight %0d, diagonal %0d; %0d mismatches",
             results_seen, hit_tally[spc_pkg::HIT_NONE], hit_tally[spc_pkg::HIT_STRAIGHT],
             hit_tally[spc_pkg::HIT_DIAGONAL], mismatches);
    if (mismatches == 0) begin
      $display("shape_pair_collision_test_unit test passed");
    end else begin
      $display("shape_pair_collision_test_unit test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/spc_pkg.sv
src/spc_in_if.sv
src/spc_out_if.sv
src/spc_seg_lane.sv
src/shape_pair_collision_test_unit.sv
src/spc_checker.sv
tb/shape_pair_collision_test_unit_test.sv
